[rtl/core/multi_stop_color_gradient_defines.svh]
// Assertion macros used by the checker file of the color gradient block.
`ifndef MULTI_STOP_COLOR_GRADIENT_DEFINES_SVH
`define MULTI_STOP_COLOR_GRADIENT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MSCG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gradient check failed: same-cycle rule");

// Next-cycle implication, disabled while reset is asserted.
`define MSCG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gradient check failed: next-cycle rule");

`endif

[rtl/core/mscg_pkg.sv]
package mscg_pkg;

	// Default sizes of the block.
	localparam int STOP_SLOTS_DEF = 6;
	localparam int POS_BITS_DEF   = 10;

	// Stop register layout: position above the 24-bit color.
	localparam int STOP_W       = 34;
	localparam int COLOR_W      = 24;
	localparam int CHAN_W       = 8;
	localparam int CHANNELS     = 3;
	localparam int CNT_W        = 3;

	// Pipeline shape: four front stages, then one divider stage per quotient bit.
	localparam int FRONT_STAGES = 4;
	localparam int PIPE_DEPTH   = FRONT_STAGES + CHAN_W;

	// Interpolation modes.
	localparam logic MODE_LINEAR = 1'b0;
	localparam logic MODE_STAIRS = 1'b1;

	// Stop zero comes out of reset at position zero in white.
	localparam logic [STOP_W-1:0] STOP0_RESET = STOP_W'(24'hFFFFFF);

endpackage

[rtl/core/mscg_if.sv]
// Position channel: one sample position per item.
interface mscg_pos_if import mscg_pkg::*; #(
	parameter int POS_BITS = POS_BITS_DEF
) ();
	logic                valid;
	logic                ready;
	logic [POS_BITS-1:0] sample_pos;

	modport source (output valid, output sample_pos, input ready);
	modport sink (input valid, input sample_pos, output ready);
endinterface

// Color channel: one RGB color per item.
interface mscg_color_if import mscg_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

[rtl/core/multi_stop_color_gradient.sv]
// Piecewise linear or stairs color map with up to STOP_SLOTS stops.
// Channels: "sample" carries a position item in, "color" carries the RGB item
// out; both are valid/ready handshakes, an item moves when both are high.
// Configuration: cfg_we writes cfg_data into register cfg_index (stops first,
// then stop count, then mode); write only while no item is in flight.
// Throughput: one item per clock while "color" is ready. Depth: 12 register stages (FRONT_STAGES
// + 8), and "color" is driven straight from the last of them. The
// depth is set by the restoring divider, which resolves one quotient bit per
// stage for all three channels after a compare stage, a stop select stage, a
// difference stage and a multiply stage.
// Reset: valid bits clear, the stops return to white at zero and black at
// full scale, two stops in use, linear mode.
// Stall: each stage holds its item while the one after it is full and
// stalled; empty stages still fill, so "sample" keeps accepting until all
// 12 stages hold items. Nothing is dropped or repeated.
module multi_stop_color_gradient import mscg_pkg::*; #(
	parameter int STOP_SLOTS = STOP_SLOTS_DEF,
	parameter int POS_BITS   = POS_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [$clog2(STOP_SLOTS + 2)-1:0]     cfg_index,
	input  logic [STOP_W-1:0]                     cfg_data,
	mscg_pos_if.sink                              sample,
	mscg_color_if.source                          color
);

	localparam int IDX_W = $clog2(STOP_SLOTS + 2);
	localparam int SEL_W = $clog2(STOP_SLOTS);
	localparam int NUM_W = CHAN_W + POS_BITS;
	localparam int LAST  = PIPE_DEPTH;

	localparam logic [IDX_W-1:0]    REG_STOP_COUNT  = IDX_W'(STOP_SLOTS);
	localparam logic [IDX_W-1:0]    REG_INTERP_MODE = IDX_W'(STOP_SLOTS + 1);
	localparam logic [POS_BITS-1:0] FULL_SCALE      = '1;
	localparam logic [STOP_W-1:0]   STOP1_RESET     = STOP_W'(FULL_SCALE) << COLOR_W;

	typedef logic [CHANNELS-1:0][CHAN_W-1:0] color_t;

	typedef struct packed {
		logic                             direct;
		color_t                           col;
		logic [CHANNELS-1:0][NUM_W-1:0]   rem;
		logic [POS_BITS-1:0]              span;
	} div_stage_t;

	// Configuration registers.
	logic [STOP_W-1:0] stop_q [STOP_SLOTS];
	logic [CNT_W-1:0]  count_q;
	logic              mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < STOP_SLOTS; k++) begin
				if (k == 0) begin
					stop_q[k] <= STOP0_RESET;
				end else if (k == 1) begin
					stop_q[k] <= STOP1_RESET;
				end else begin
					stop_q[k] <= '0;
				end
			end
			count_q   <= CNT_W'(2);
			mode_q    <= MODE_LINEAR;
		end else if (cfg_we) begin
			for (int k = 0; k < STOP_SLOTS; k++) begin
				if (cfg_index == IDX_W'(k)) begin
					stop_q[k] <= cfg_data;
				end
			end
			if (cfg_index == REG_STOP_COUNT) begin
				count_q <= cfg_data[CNT_W-1:0];
			end
			if (cfg_index == REG_INTERP_MODE) begin
				mode_q <= cfg_data[0];
			end
		end
	end

	// Stop fields and the index of the last stop in use.
	logic [POS_BITS-1:0] pos_c  [STOP_SLOTS];
	color_t              col_c  [STOP_SLOTS];
	logic [POS_BITS-1:0] ppos_c [STOP_SLOTS];
	color_t              pcol_c [STOP_SLOTS];
	logic [SEL_W-1:0]    last_c;

	always_comb begin
		for (int k = 0; k < STOP_SLOTS; k++) begin
			pos_c[k] = POS_BITS'(stop_q[k] >> COLOR_W);
			col_c[k] = stop_q[k][COLOR_W-1:0];
		end
		for (int k = 0; k < STOP_SLOTS; k++) begin
			ppos_c[k] = pos_c[(k == 0) ? 0 : k - 1];
			pcol_c[k] = col_c[(k == 0) ? 0 : k - 1];
		end
		if (count_q < CNT_W'(2)) begin
			last_c = SEL_W'(1);
		end else if (32'(count_q) > STOP_SLOTS) begin
			last_c = SEL_W'(STOP_SLOTS - 1);
		end else begin
			last_c = SEL_W'(count_q - CNT_W'(1));
		end
	end

	// Stage enables: a stage loads when it is empty or the next one loads.
	logic       valid_s [1:LAST];
	logic [LAST+1:1] en;

	always_comb begin
		en[LAST+1] = color.ready;
		for (int s = LAST; s >= 1; s--) begin
			en[s] = !valid_s[s] || en[s+1];
		end
	end

	assign sample.ready = en[1];

	// Valid bits travel with the items.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 1; s <= LAST; s++) begin
				valid_s[s] <= 1'b0;
			end
		end else begin
			if (en[1]) begin
				valid_s[1] <= sample.valid;
			end
			for (int s = 2; s <= LAST; s++) begin
				if (en[s]) begin
					valid_s[s] <= valid_s[s-1];
				end
			end
		end
	end

	// Stage 1: compare the position against every stop.
	logic [POS_BITS-1:0]   p_s1;
	logic [STOP_SLOTS-1:0] ge_s1;
	logic [STOP_SLOTS-1:0] gt_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			p_s1 <= sample.sample_pos;
			for (int k = 0; k < STOP_SLOTS; k++) begin
				ge_s1[k] <= pos_c[k] >= sample.sample_pos;
				gt_s1[k] <= pos_c[k] > sample.sample_pos;
			end
		end
	end

	// Stage 2: pick the stop, and whether its color is taken as it stands.
	logic             lin_found;
	logic             lin_exact;
	logic [SEL_W-1:0] lin_k;
	logic             st_found;
	logic [SEL_W-1:0] st_k;
	logic [SEL_W-1:0] idx_c;
	logic             direct_c;

	always_comb begin
		lin_found = 1'b0;
		lin_exact = 1'b0;
		lin_k     = '0;
		st_found  = 1'b0;
		st_k      = '0;
		// Walk downward so the lowest matching stop wins.
		for (int k = STOP_SLOTS - 1; k >= 1; k--) begin
			if (SEL_W'(k) <= last_c && ge_s1[k]) begin
				lin_found = 1'b1;
				lin_exact = !gt_s1[k];
				lin_k     = SEL_W'(k);
			end
			if (SEL_W'(k) <= last_c && gt_s1[k]) begin
				st_found = 1'b1;
				st_k     = SEL_W'(k);
			end
		end

		direct_c = 1'b1;
		if (p_s1 == '0) begin
			idx_c = '0;
		end else if (p_s1 == FULL_SCALE) begin
			idx_c = last_c;
		end else if (mode_q == MODE_STAIRS) begin
			idx_c = st_found ? st_k - SEL_W'(1) : last_c;
		end else if (ge_s1[0]) begin
			idx_c = '0;
		end else if (!lin_found) begin
			idx_c = last_c;
		end else begin
			idx_c    = lin_k;
			direct_c = lin_exact;
		end
	end

	logic [POS_BITS-1:0] p_s2;
	logic [SEL_W-1:0]    idx_s2;
	logic                direct_s2;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			p_s2      <= p_s1;
			idx_s2    <= idx_c;
			direct_s2 <= direct_c;
		end
	end

	// Stage 3: fetch the stop pair and form the position differences.
	color_t              c0_c;
	color_t              c1_c;
	logic [POS_BITS-1:0] p0_c;
	logic [POS_BITS-1:0] p1_c;

	always_comb begin
		c0_c = col_c[0];
		c1_c = col_c[0];
		p0_c = pos_c[0];
		p1_c = pos_c[0];
		for (int k = 0; k < STOP_SLOTS; k++) begin
			if (idx_s2 == SEL_W'(k)) begin
				c1_c = col_c[k];
				p1_c = pos_c[k];
				c0_c = pcol_c[k];
				p0_c = ppos_c[k];
			end
		end
	end

	color_t              c0_s3;
	color_t              c1_s3;
	logic [POS_BITS-1:0] d_s3;
	logic [POS_BITS-1:0] e_s3;
	logic [POS_BITS-1:0] span_s3;
	logic                direct_s3;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			c0_s3     <= c0_c;
			c1_s3     <= c1_c;
			d_s3      <= p_s2 - p0_c;
			e_s3      <= p1_c - p_s2;
			span_s3   <= p1_c - p0_c;
			direct_s3 <= direct_s2;
		end
	end

	// Stage 4: weighted sum of the two colors, per channel.
	div_stage_t data_s [FRONT_STAGES:LAST];

	always_ff @(posedge clk) begin
		if (en[FRONT_STAGES]) begin
			data_s[FRONT_STAGES].direct <= direct_s3;
			data_s[FRONT_STAGES].col    <= c1_s3;
			data_s[FRONT_STAGES].span   <= span_s3;
			for (int ch = 0; ch < CHANNELS; ch++) begin
				data_s[FRONT_STAGES].rem[ch] <=
					NUM_W'(c1_s3[ch]) * NUM_W'(d_s3) + NUM_W'(c0_s3[ch]) * NUM_W'(e_s3);
			end
		end
	end

	// Stages 5 to 12: restoring division, most significant quotient bit first.
	for (genvar s = FRONT_STAGES + 1; s <= LAST; s++) begin : g_div
		localparam int BIT = LAST - s;

		div_stage_t       nxt;
		logic [NUM_W-1:0] shifted;

		always_comb begin
			shifted = NUM_W'(data_s[s-1].span) << BIT;
			nxt     = data_s[s-1];
			for (int ch = 0; ch < CHANNELS; ch++) begin
				if (data_s[s-1].rem[ch] >= shifted) begin
					nxt.rem[ch] = data_s[s-1].rem[ch] - shifted;
					if (!data_s[s-1].direct) begin
						nxt.col[ch][BIT] = 1'b1;
					end
				end else if (!data_s[s-1].direct) begin
					nxt.col[ch][BIT] = 1'b0;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[s]) begin
				data_s[s] <= nxt;
			end
		end
	end

	// Output register is the last divider stage.
	assign color.valid = valid_s[LAST];
	assign color.red   = data_s[LAST].col[2];
	assign color.green = data_s[LAST].col[1];
	assign color.blue  = data_s[LAST].col[0];

endmodule

[rtl/core/mscg_checker.sv]
`include "multi_stop_color_gradient_defines.svh"

// Port-level checks of the color gradient block.
module mscg_checker import mscg_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [CHAN_W-1:0] red,
	input logic [CHAN_W-1:0] green,
	input logic [CHAN_W-1:0] blue
);

	localparam int OCC_W = $clog2(PIPE_DEPTH + 2);

	logic [OCC_W-1:0]        outstanding_q;
	logic [3*CHAN_W-1:0]     out_word;
	logic                    in_take;
	logic                    out_take;

	assign out_word = {red, green, blue};
	assign in_take  = in_valid && in_ready;
	assign out_take = out_valid && out_ready;

	// Items accepted but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else if (in_take && !out_take) begin
			outstanding_q <= outstanding_q + OCC_W'(1);
		end else if (out_take && !in_take) begin
			outstanding_q <= outstanding_q - OCC_W'(1);
		end
	end

	// A stalled result stays and keeps its color.
	`MSCG_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_word))
	// No result without an item in flight.
	`MSCG_ASSERT_NOW(a_no_phantom, clk, arst_n, out_valid, outstanding_q != '0)
	// The pipeline never holds more items than it has stages.
	`MSCG_ASSERT_NOW(a_capacity, clk, arst_n, 1'b1, outstanding_q <= OCC_W'(PIPE_DEPTH))
	// A draining output lets every stage advance, so the input is open.
	`MSCG_ASSERT_NOW(a_ready_flow, clk, arst_n, out_ready, in_ready)

endmodule

bind multi_stop_color_gradient mscg_checker u_mscg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.out_valid (color.valid),
	.out_ready (color.ready),
	.red       (color.red),
	.green     (color.green),
	.blue      (color.blue)
);

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import mscg_pkg::*;

	localparam int STOP_SLOTS = STOP_SLOTS_DEF;
	localparam int POS_BITS   = POS_BITS_DEF;
	localparam int IDX_W      = $clog2(STOP_SLOTS + 2);
	localparam int FULL_SCALE = (1 << POS_BITS) - 1;

	// Register map of the configuration port.
	localparam logic [IDX_W-1:0] REG_STOP_FIRST  = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_STOP_COUNT  = IDX_W'(STOP_SLOTS);
	localparam logic [IDX_W-1:0] REG_INTERP_MODE = IDX_W'(STOP_SLOTS + 1);

	localparam int NUM_PHASES      = 8;
	localparam int ITEMS_PER_PHASE = 50;
	localparam int HOLD_CYCLES     = 60;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} rgb_t;

	// One row of the directed table: either a register write or a position.
	typedef struct packed {
		bit                  is_cfg;
		logic [IDX_W-1:0]    idx;
		logic [STOP_W-1:0]   data;
		logic [POS_BITS-1:0] pos;
		bit                  known;
		rgb_t                color;
	} dir_row_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [IDX_W-1:0]    cfg_index;
	logic [STOP_W-1:0]   cfg_data;

	mscg_pos_if #(.POS_BITS(POS_BITS)) sample_ch ();
	mscg_color_if                      color_ch ();

	multi_stop_color_gradient #(
		.STOP_SLOTS(STOP_SLOTS),
		.POS_BITS  (POS_BITS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.sample   (sample_ch.sink),
		.color    (color_ch.source)
	);

	// Local copy of the block's registers, used by the color predictor.
	logic [STOP_W-1:0] model_stop [STOP_SLOTS];
	logic [CNT_W-1:0]  model_count;
	logic              model_mode;

	rgb_t     expected_colors [$];
	dir_row_t dir_rows [$];
	int       mismatches;
	int       colors_checked;
	int       directed_items;
	int       random_items;
	int       settings_used;
	bit       no_idle;
	bit       hold_req;

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Safety net against a hung handshake.
	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

	function automatic logic [POS_BITS-1:0] stop_pos_of(input int i);
		return model_stop[i][COLOR_W +: POS_BITS];
	endfunction

	function automatic rgb_t stop_color_of(input int i);
		return rgb_t'(model_stop[i][COLOR_W-1:0]);
	endfunction

	// Predicts the color the block gives for one sample position.
	function automatic rgb_t gradient_color(input logic [POS_BITS-1:0] p);
		int unsigned n;
		int unsigned k;
		int unsigned sel;
		int unsigned p0;
		int unsigned p1;
		int unsigned a;
		int unsigned b;
		int unsigned ch;
		logic [COLOR_W-1:0] c0;
		logic [COLOR_W-1:0] c1;
		logic [COLOR_W-1:0] mix;
		n = model_count;
		if (n < 2) n = 2;
		if (n > STOP_SLOTS) n = STOP_SLOTS;
		if (p == 0) return stop_color_of(0);
		if (p >= FULL_SCALE) return stop_color_of(n - 1);
		// Stairs mode holds the last stop at or below the position.
		if (model_mode == MODE_STAIRS) begin
			sel = 0;
			for (k = 1; k < n; k++) begin
				if (stop_pos_of(k) <= p) sel = k;
				else break;
			end
			return stop_color_of(sel);
		end
		if (p <= stop_pos_of(0)) return stop_color_of(0);
		// Linear mode blends the two stops around the position.
		for (k = 1; k < n; k++) begin
			p1 = stop_pos_of(k);
			if (p1 >= p) begin
				if (p1 == p) return stop_color_of(k);
				p0 = stop_pos_of(k - 1);
				c0 = model_stop[k-1][COLOR_W-1:0];
				c1 = model_stop[k][COLOR_W-1:0];
				for (ch = 0; ch < CHANNELS; ch++) begin
					a = c0[ch*CHAN_W +: CHAN_W];
					b = c1[ch*CHAN_W +: CHAN_W];
					mix[ch*CHAN_W +: CHAN_W] = CHAN_W'((b * (p - p0) + a * (p1 - p)) / (p1 - p0));
				end
				return rgb_t'(mix);
			end
		end
		return stop_color_of(n - 1);
	endfunction

	function automatic dir_row_t cfg_row(input logic [IDX_W-1:0] idx, input logic [STOP_W-1:0] data);
		dir_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.data = data;
		return r;
	endfunction

	function automatic dir_row_t pos_row(input logic [POS_BITS-1:0] p);
		dir_row_t r;
		r = '0;
		r.pos = p;
		return r;
	endfunction

	function automatic dir_row_t known_row(input logic [POS_BITS-1:0] p, input logic [COLOR_W-1:0] c);
		dir_row_t r;
		r = '0;
		r.pos = p;
		r.known = 1'b1;
		r.color = rgb_t'(c);
		return r;
	endfunction

	// Appends one row to the directed table.
	function automatic void add_row(input dir_row_t r);
		dir_rows = {dir_rows, r};
	endfunction

	// Random positions favor the stops and their neighbors, and the ends of the scale.
	function automatic logic [POS_BITS-1:0] pick_pos();
		int r;
		int v;
		r = $urandom_range(0, 19);
		if (r < 11) return POS_BITS'($urandom_range(0, FULL_SCALE));
		if (r < 17) begin
			v = int'(stop_pos_of($urandom_range(0, STOP_SLOTS - 1))) + $urandom_range(0, 2) - 1;
			if (v < 0) v = 0;
			if (v > FULL_SCALE) v = FULL_SCALE;
			return POS_BITS'(v);
		end
		case (r)
			17: return POS_BITS'(0);
			18: return POS_BITS'(1);
			default: return POS_BITS'(FULL_SCALE - (r - 19));
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	// Writes one register; called at a rising edge, returns at a rising edge.
	task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [STOP_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx < REG_STOP_COUNT) model_stop[idx] = data;
		else if (idx == REG_STOP_COUNT) model_count = data[CNT_W-1:0];
		else if (idx == REG_INTERP_MODE) model_mode = data[0];
	endtask

	// Offers one position and waits until the block takes it.
	task automatic send_pos(input logic [POS_BITS-1:0] p, input rgb_t want);
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		sample_ch.valid      <= 1'b1;
		sample_ch.sample_pos <= p;
		do @(negedge clk); while (!sample_ch.ready);
		expected_colors = {expected_colors, want};
		@(posedge clk);
	endtask

	// Stops offering and lets every item in flight come out.
	task automatic wait_idle();
		sample_ch.valid <= 1'b0;
		while (expected_colors.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH) @(posedge clk);
	endtask

	// Picks a stop setting for one random phase; the first two are the extremes.
	task automatic random_setting(input int phase);
		logic [POS_BITS-1:0] ps [STOP_SLOTS];
		logic [POS_BITS-1:0] t;
		int i;
		int j;
		if (phase < 2) begin
			for (i = 0; i < STOP_SLOTS + 2; i++) cfg_write(IDX_W'(i), (phase == 0) ? '1 : '0);
			return;
		end
		for (i = 0; i < STOP_SLOTS; i++) ps[i] = POS_BITS'($urandom_range(0, FULL_SCALE));
		// Most phases use ascending stops; every fourth one keeps them scrambled.
		if (phase % 4 != 3) begin
			for (i = 1; i < STOP_SLOTS; i++) begin
				for (j = i; j > 0 && ps[j-1] > ps[j]; j--) begin
					t = ps[j];
					ps[j] = ps[j-1];
					ps[j-1] = t;
				end
			end
			if ($urandom_range(0, 1)) ps[0] = '0;
		end
		for (i = 0; i < STOP_SLOTS; i++) cfg_write(REG_STOP_FIRST + IDX_W'(i), {ps[i], COLOR_W'($urandom)});
		if ($urandom_range(0, 3) == 0) cfg_write(REG_STOP_COUNT, STOP_W'($urandom_range(0, 7)));
		else cfg_write(REG_STOP_COUNT, STOP_W'($urandom_range(2, STOP_SLOTS)));
		cfg_write(REG_INTERP_MODE, (phase % 2 == 1) ? STOP_W'(MODE_STAIRS) : STOP_W'(MODE_LINEAR));
	endtask

	// Color receiver: random stalls, one long hold-off on request.
	initial begin
		int held;
		color_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				color_ch.ready <= 1'b0;
				for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
				color_ch.ready <= 1'b1;
			end else if (!no_idle && $urandom_range(0, 5) == 0) begin
				color_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				color_ch.ready <= 1'b1;
			end else begin
				color_ch.ready <= 1'b1;
			end
		end
	end

	// Color checker: an item seen here moves at the next rising edge.
	always @(negedge clk) begin
		rgb_t want;
		if (arst_n && color_ch.valid && color_ch.ready) begin
			if (expected_colors.size() == 0) begin
				report_mismatch($sformatf("color %02h%02h%02h with none expected",
					color_ch.red, color_ch.green, color_ch.blue));
			end else begin
				want = expected_colors.pop_front();
				colors_checked++;
				if (color_ch.red !== want.red)
					report_mismatch($sformatf("red %02h, expected %02h", color_ch.red, want.red));
				if (color_ch.green !== want.green)
					report_mismatch($sformatf("green %02h, expected %02h", color_ch.green, want.green));
				if (color_ch.blue !== want.blue)
					report_mismatch($sformatf("blue %02h, expected %02h", color_ch.blue, want.blue));
			end
		end
	end

	// Main sequence: reset, directed table, random phases, drain.
	initial begin
		int i;
		int ph;
		int n;
		dir_row_t r;
		arst_n               <= 1'b0;
		cfg_we               <= 1'b0;
		cfg_index            <= '0;
		cfg_data             <= '0;
		sample_ch.valid      <= 1'b0;
		sample_ch.sample_pos <= '0;
		mismatches     = 0;
		colors_checked = 0;
		directed_items = 0;
		random_items   = 0;
		settings_used  = 1;
		no_idle        = 1'b0;
		hold_req       = 1'b0;
		for (i = 0; i < STOP_SLOTS; i++) model_stop[i] = '0;
		model_stop[0] = STOP0_RESET;
		model_stop[1] = {POS_BITS'(FULL_SCALE), COLOR_W'(0)};
		model_count   = CNT_W'(2);
		model_mode    = MODE_LINEAR;

		// Reset-state gradient: white at zero down to black at full scale.
		add_row(known_row(10'd0, 24'hFFFFFF));
		add_row(known_row(10'd1023, 24'h000000));
		add_row(pos_row(10'd512));
		add_row(pos_row(10'd1));
		add_row(pos_row(10'd1022));
		// Four ascending stops, exact matches and a blend.
		add_row(cfg_row(REG_STOP_FIRST + IDX_W'(0), {10'd0, 24'hFF0000}));
		add_row(cfg_row(REG_STOP_FIRST + IDX_W'(1), {10'd300, 24'h00FF00}));
		add_row(cfg_row(REG_STOP_FIRST + IDX_W'(2), {10'd700, 24'h0000FF}));
		add_row(cfg_row(REG_STOP_FIRST + IDX_W'(3), {10'd1023, 24'hFFFFFF}));
		add_row(cfg_row(REG_STOP_COUNT, STOP_W'(4)));
		add_row(known_row(10'd300, 24'h00FF00));
		add_row(known_row(10'd700, 24'h0000FF));
		add_row(pos_row(10'd150));
		add_row(known_row(10'd1023, 24'hFFFFFF));
		// Stairs mode on the same stops.
		add_row(cfg_row(REG_INTERP_MODE, STOP_W'(MODE_STAIRS)));
		add_row(known_row(10'd299, 24'hFF0000));
		add_row(known_row(10'd300, 24'h00FF00));
		add_row(known_row(10'd1000, 24'h0000FF));
		// Stop count above the slot count uses all slots.
		add_row(cfg_row(REG_STOP_COUNT, STOP_W'(7)));
		add_row(pos_row(10'd1022));
		add_row(known_row(10'd1023, 24'h000000));
		// Stop counts below two use two stops.
		add_row(cfg_row(REG_INTERP_MODE, STOP_W'(MODE_LINEAR)));
		add_row(cfg_row(REG_STOP_COUNT, STOP_W'(0)));
		add_row(known_row(10'd1023, 24'h00FF00));
		add_row(pos_row(10'd150));
		add_row(cfg_row(REG_STOP_COUNT, STOP_W'(1)));
		add_row(known_row(10'd1023, 24'h00FF00));
		// Stops out of order.
		add_row(cfg_row(REG_STOP_COUNT, STOP_W'(3)));
		add_row(cfg_row(REG_STOP_FIRST + IDX_W'(1), {10'd800, 24'h123456}));
		add_row(cfg_row(REG_STOP_FIRST + IDX_W'(2), {10'd400, 24'hABCDEF}));
		add_row(pos_row(10'd500));
		add_row(known_row(10'd900, 24'hABCDEF));
		// Two stops at the same position, and a first stop above the sample.
		add_row(cfg_row(REG_STOP_FIRST + IDX_W'(1), {10'd400, 24'h00FF00}));
		add_row(cfg_row(REG_STOP_FIRST + IDX_W'(2), {10'd400, 24'h0000FF}));
		add_row(known_row(10'd400, 24'h00FF00));
		add_row(cfg_row(REG_STOP_FIRST + IDX_W'(0), {10'd200, 24'hFF0000}));
		add_row(known_row(10'd100, 24'hFF0000));
		add_row(cfg_row(REG_INTERP_MODE, STOP_W'(MODE_STAIRS)));
		add_row(known_row(10'd400, 24'h0000FF));
		add_row(known_row(10'd100, 24'hFF0000));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part.
		foreach (dir_rows[i]) begin
			r = dir_rows[i];
			if (r.is_cfg) begin
				wait_idle();
				cfg_write(r.idx, r.data);
				settings_used++;
			end else begin
				send_pos(r.pos, r.known ? r.color : gradient_color(r.pos));
				directed_items++;
			end
		end

		// Random part, one stop setting per phase; the last phases run without idling.
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			wait_idle();
			random_setting(ph);
			settings_used++;
			no_idle = (ph >= NUM_PHASES - 2);
			if (ph == 2 || ph == 5) hold_req = 1'b1;
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				r.pos = pick_pos();
				send_pos(r.pos, gradient_color(r.pos));
				random_items++;
			end
		end

		wait_idle();
		repeat (4) @(posedge clk);
		$display("tb: %0d directed and %0d random positions over %0d stop settings",
			directed_items, random_items, settings_used);
		$display("tb: %0d colors compared, %0d mismatches", colors_checked, mismatches);
		if (mismatches == 0 && expected_colors.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/mscg_pkg.sv
rtl/core/mscg_if.sv
rtl/core/multi_stop_color_gradient.sv
rtl/core/mscg_checker.sv
tb/sv/tb_top.sv
